/* hdl/lmsf_pkg.sv */
// Shared types and constants of the longest merged segment finder.
// No dependencies; every other file imports this package.
package lmsf_pkg;

	localparam int unsigned NDIST_W     = 12;
	localparam int unsigned RSTART_W    = 12;
	localparam int unsigned REND_W      = 13;
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned SECT_W      = 12;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [REND_W-1:0] RANGE_END_RST = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEIGHBOR_DIST = 2'd0,
		REG_RANGE_START   = 2'd1,
		REG_RANGE_END     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [NDIST_W-1:0]  neighbor_dist;
		logic [RSTART_W-1:0] range_start;
		logic [REND_W-1:0]   range_end;
	} cfg_regs_t;

	typedef struct packed {
		logic close;
		logic last;
	} evt_flags_t;

endpackage

/* hdl/lmsf_intf.sv */
// Handshake channel interfaces: sample input, result output, register write.
// Depends on lmsf_pkg for field widths.
interface lmsf_sample_if import lmsf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface lmsf_result_if import lmsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SECT_W-1:0] section_start;
	logic [SECT_W-1:0] section_end;
	logic              found;

	modport source (output valid, output section_start, output section_end, output found,
		input ready);
	modport sink   (input valid, input section_start, input section_end, input found,
		output ready);
endinterface

interface lmsf_cfg_if import lmsf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/longest_merged_segment_finder_core.sv */
// Top level of the longest merged segment finder: registers, front, queue, back.
// Depends on lmsf_pkg, lmsf_intf, lmsf_front, lmsf_fifo and lmsf_back.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  cfg      | in  | valid/ready  | index (2b), data (13b)
//  samples  | in  | valid/ready  | sample (16b), last (1b)
//  results  | out | valid/ready  | section_start (12b), section_end (12b), found
//
// One sample per cycle while the queue has room; the front end decides edges
// combinationally; the back end merges one event per cycle unless a result stalls;
// the last event passes through the queue, then the back end registers the result.
// arst_n clears scan state and sets registers to their reset values.
// A stalled result output holds the back end; the two-entry event queue lets the
// front keep taking samples until it fills. cfg.ready is always high.
module longest_merged_segment_finder_core import lmsf_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	lmsf_cfg_if.sink      cfg,
	lmsf_sample_if.sink   samples,
	lmsf_result_if.source results
);

	localparam int unsigned PW    = $clog2(MAX_LEN);
	localparam int unsigned EVT_W = 2 + 2 * PW;

	cfg_regs_t        cfg_q;
	logic             fifo_push_valid;
	logic             fifo_push_ready;
	logic [EVT_W-1:0] fifo_push_data;
	logic             fifo_pop_valid;
	logic             fifo_pop_ready;
	logic [EVT_W-1:0] fifo_pop_data;
	evt_flags_t       head_flags;

	assign cfg.ready  = 1'b1;
	assign head_flags = fifo_pop_data[EVT_W-1 -: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neighbor_dist <= '0;
			cfg_q.range_start   <= '0;
			cfg_q.range_end     <= RANGE_END_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_NEIGHBOR_DIST: cfg_q.neighbor_dist <= cfg.data[NDIST_W-1:0];
				REG_RANGE_START:   cfg_q.range_start   <= cfg.data[RSTART_W-1:0];
				REG_RANGE_END:     cfg_q.range_end     <= cfg.data[REND_W-1:0];
				default: ;
			endcase
		end
	end

	lmsf_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg_q),
		.push_ready (fifo_push_ready),
		.push_valid (fifo_push_valid),
		.push_data  (fifo_push_data)
	);

	lmsf_fifo #(.DATA_W(EVT_W)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fifo_push_valid),
		.push_ready (fifo_push_ready),
		.push_data  (fifo_push_data),
		.pop_valid  (fifo_pop_valid),
		.pop_ready  (fifo_pop_ready),
		.pop_data   (fifo_pop_data)
	);

	lmsf_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (fifo_pop_valid),
		.evt_ready     (fifo_pop_ready),
		.evt_data      (fifo_pop_data),
		.neighbor_dist (cfg_q.neighbor_dist),
		.results       (results)
	);

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push_valid |-> fifo_push_ready)
		else $error("event pushed into full queue");

	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop_valid && fifo_pop_ready && head_flags.last |=> results.valid)
		else $error("last event produced no result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.found |->
			results.section_start == '0 && results.section_end == '0)
		else $error("result without a segment carries nonzero bounds");

endmodule

/* hdl/lmsf_front.sv */
// Front end: takes samples, tracks edges and open segments, emits close and last events.
// Depends on lmsf_pkg and lmsf_sample_if.
module lmsf_front import lmsf_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lmsf_sample_if.sink                   samples,
	input  cfg_regs_t                     cfg,
	input  logic                          push_ready,
	output logic                          push_valid,
	output logic [2+2*$clog2(MAX_LEN)-1:0] push_data
);

	localparam int unsigned PW = $clog2(MAX_LEN);
	localparam int unsigned KW = $clog2(MAX_LEN + 1);
	localparam int unsigned CW = ((KW > REND_W) ? KW : REND_W) + 1;

	logic [KW-1:0] idx_q;
	logic          prev_q;
	logic          in_seg_q;
	logic [PW-1:0] seg_q;

	logic          cur;
	logic          accept;
	logic [CW-1:0] k_w;
	logic [CW-1:0] lo_w;
	logic [CW-1:0] rend_w;
	logic          in_range;
	logic [PW-1:0] p;
	logic          opening;
	logic          in2;
	logic [PW-1:0] start2;
	logic          close_edge;
	logic          in3;
	logic          close_end;
	evt_flags_t    flags;
	logic [PW-1:0] evt_e;

	always_comb begin
		cur      = |samples.sample;
		k_w      = CW'(idx_q);
		lo_w     = CW'(cfg.range_start);
		rend_w   = (CW'(cfg.range_end) < CW'(MAX_LEN)) ? CW'(cfg.range_end) : CW'(MAX_LEN);
		in_range = (k_w > lo_w) && (k_w < rend_w);
		p        = PW'(idx_q - KW'(1));
		opening  = in_range && !in_seg_q && ((k_w == lo_w + CW'(1)) || (!prev_q && cur));
		in2      = in_seg_q || opening;
		start2   = opening ? p : seg_q;
		close_edge = in_range && in2 && prev_q && !cur;
		in3      = in2 && !close_edge;
		close_end  = in3 && ((k_w + CW'(1) == rend_w) || samples.last);
		evt_e    = close_edge ? p : PW'(idx_q);
		flags.close = close_edge || close_end;
		flags.last  = samples.last;
	end

	assign samples.ready = push_ready;
	assign accept        = samples.valid && push_ready;
	assign push_valid    = accept && (flags.close || flags.last);
	assign push_data     = {flags, start2, evt_e};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			prev_q   <= 1'b0;
			in_seg_q <= 1'b0;
			seg_q    <= '0;
		end else if (accept) begin
			if (samples.last)
				idx_q <= '0;
			else if (idx_q != KW'(MAX_LEN))
				idx_q <= idx_q + KW'(1);
			prev_q   <= !samples.last && cur;
			in_seg_q <= !samples.last && in3 && !close_end;
			seg_q    <= start2;
		end
	end

endmodule

/* hdl/lmsf_fifo.sv */
// Short event queue between front and back end.
// Depends on lmsf_pkg for the queue depth.
module lmsf_fifo import lmsf_pkg::*; #(
	parameter int unsigned DATA_W = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

/* hdl/lmsf_back.sv */
// Back end: merges closed segments into groups, keeps the longest, reports on last.
// Depends on lmsf_pkg and lmsf_result_if.
module lmsf_back import lmsf_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	output logic                           evt_ready,
	input  logic [2+2*$clog2(MAX_LEN)-1:0] evt_data,
	input  logic [NDIST_W-1:0]             neighbor_dist,
	lmsf_result_if.source                  results
);

	localparam int unsigned PW = $clog2(MAX_LEN);
	localparam int unsigned DW = (PW > NDIST_W) ? PW : NDIST_W;

	logic [PW-1:0] gs_q, ge_q, bs_q, be_q;
	logic          gv_q, bv_q;
	logic          out_valid_q;
	logic [SECT_W-1:0] start_q, end_q;
	logic          found_q;

	evt_flags_t    flags;
	logic [PW-1:0] s, e;
	logic          pop;
	logic          merge;
	logic          beats1;
	logic          beats2;
	logic [PW-1:0] n_gs, n_ge, n_bs, n_be;
	logic          n_gv, n_bv;
	logic          f_take;
	logic          fin_found;
	logic [PW-1:0] fin_s, fin_e;
	logic [PW+SECT_W-1:0] wide_s, wide_e;

	assign {flags, s, e} = evt_data;
	assign evt_ready     = !out_valid_q || results.ready;
	assign pop           = evt_valid && evt_ready;

	always_comb begin
		merge  = (s <= ge_q) || (DW'(s - ge_q) <= DW'(neighbor_dist));
		beats1 = !bv_q || ((ge_q - gs_q) >= (be_q - bs_q));
		n_gs = gs_q;
		n_ge = ge_q;
		n_gv = gv_q;
		n_bs = bs_q;
		n_be = be_q;
		n_bv = bv_q;
		if (flags.close) begin
			if (!gv_q) begin
				n_gs = s;
				n_ge = e;
				n_gv = 1'b1;
			end else if (merge) begin
				n_ge = e;
			end else begin
				if (beats1) begin
					n_bs = gs_q;
					n_be = ge_q;
					n_bv = 1'b1;
				end
				n_gs = s;
				n_ge = e;
			end
		end
		beats2    = !n_bv || ((n_ge - n_gs) >= (n_be - n_bs));
		f_take    = n_gv && beats2;
		fin_found = f_take || n_bv;
		fin_s     = !fin_found ? '0 : (f_take ? n_gs : n_bs);
		fin_e     = !fin_found ? '0 : (f_take ? n_ge : n_be);
		wide_s    = {{SECT_W{1'b0}}, fin_s};
		wide_e    = {{SECT_W{1'b0}}, fin_e};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= '0;
			ge_q <= '0;
			gv_q <= 1'b0;
			bs_q <= '0;
			be_q <= '0;
			bv_q <= 1'b0;
		end else if (pop) begin
			if (flags.last) begin
				gs_q <= '0;
				ge_q <= '0;
				gv_q <= 1'b0;
				bs_q <= '0;
				be_q <= '0;
				bv_q <= 1'b0;
			end else begin
				gs_q <= n_gs;
				ge_q <= n_ge;
				gv_q <= n_gv;
				bs_q <= n_bs;
				be_q <= n_be;
				bv_q <= n_bv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && flags.last)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && flags.last) begin
			start_q <= wide_s[SECT_W-1:0];
			end_q   <= wide_e[SECT_W-1:0];
			found_q <= fin_found;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.section_start = start_q;
	assign results.section_end   = end_q;
	assign results.found         = found_q;

endmodule
